// ----- rtl/core/multilevel_feedback_scheduler_defines.svh -----
// Assertion macros used by the scheduler checker.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define MLFQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define MLFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/mlfq_pkg.sv -----
package mlfq_pkg;

	localparam int PID_W = 4;
	localparam int LVL_W = 4;
	localparam int NUM_LEVELS = 10;
	localparam int FUNC_W = 2;
	localparam int STATE_W = 2;
	localparam int QL_W = 9;
	localparam int Q_W = 8;
	localparam int CNT_W = 8;
	localparam int DEFAULT_NUM_PROCS = 16;

	localparam logic [LVL_W-1:0] TOP_PRIO = 4'd9;
	localparam logic [LVL_W-1:0] MAX_ADJ_PRIO = 4'd8;
	localparam logic [CNT_W-1:0] DEFER_MAX = 8'd255;
	localparam logic [Q_W-1:0] QUANTUM_DEFAULT = 8'd100;

	localparam logic [STATE_W-1:0] ST_CURRENT = 2'd0;
	localparam logic [STATE_W-1:0] ST_BLOCKED = 2'd1;

	localparam logic CLS_CPU = 1'b0;
	localparam logic CLS_IO = 1'b1;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_RESCHED     = 2'd0,
		FUNC_DEFER_START = 2'd1,
		FUNC_DEFER_STOP  = 2'd2,
		FUNC_MAKE_READY  = 2'd3
	} func_t;

	localparam logic [Q_W-1:0] QUANTUM_TBL [NUM_LEVELS] = '{
		8'd200, 8'd180, 8'd160, 8'd120, 8'd100, 8'd80, 8'd60, 8'd40, 8'd20, 8'd10
	};

	// Request from the scheduler core to the ready levels
	typedef struct packed {
		logic             commit;
		logic             push_en;
		logic [LVL_W-1:0] push_lvl;
		logic [PID_W-1:0] push_pid;
		logic             pop_en;
		logic [LVL_W-1:0] pop_lvl;
	} lvl_req_t;

	// View of the ready levels for the item in flight
	typedef struct packed {
		logic [NUM_LEVELS-1:0] nonempty;
		logic                  pop_valid;
		logic [PID_W-1:0]      pop_pid;
	} lvl_rsp_t;

	function automatic logic [Q_W-1:0] quantum_of(input logic [LVL_W-1:0] prio);
		logic [Q_W-1:0] q;
		if (prio < LVL_W'(NUM_LEVELS)) begin
			q = QUANTUM_TBL[prio];
		end else begin
			q = QUANTUM_DEFAULT;
		end
		return q;
	endfunction

	// Move the priority by the class transition, clamped to 0..8; top level is fixed
	function automatic logic [LVL_W-1:0] adjust_prio(
		input logic [LVL_W-1:0] prio,
		input logic             orig,
		input logic             cls
	);
		logic [LVL_W:0]   up;
		logic [LVL_W-1:0] res;
		up = '0;
		res = prio;
		if (prio == TOP_PRIO) begin
			res = prio;
		end else if (orig == CLS_CPU && cls == CLS_CPU) begin
			res = (prio == '0) ? '0 : prio - 4'd1;
		end else if (orig == CLS_IO && cls == CLS_CPU) begin
			res = (prio < 4'd2) ? '0 : prio - 4'd2;
		end else begin
			up = {1'b0, prio} + ((orig == CLS_CPU) ? 5'd2 : 5'd1);
			res = (up > {1'b0, MAX_ADJ_PRIO}) ? MAX_ADJ_PRIO : up[LVL_W-1:0];
		end
		return res;
	endfunction

endpackage

// ----- rtl/core/mlfq_req_if.sv -----
interface mlfq_req_if;
	logic                             valid;
	logic                             ready;
	logic [mlfq_pkg::FUNC_W-1:0]      func;
	logic [mlfq_pkg::PID_W-1:0]       target_pid;
	logic [mlfq_pkg::LVL_W-1:0]       ready_prio;
	logic [mlfq_pkg::STATE_W-1:0]     old_state;
	logic                             old_yielded;
	logic signed [mlfq_pkg::QL_W-1:0] quantum_left;

	modport source (
		output valid, func, target_pid, ready_prio, old_state, old_yielded, quantum_left,
		input  ready
	);
	modport sink (
		input  valid, func, target_pid, ready_prio, old_state, old_yielded, quantum_left,
		output ready
	);
endinterface

// ----- rtl/core/mlfq_rsp_if.sv -----
interface mlfq_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       switched;
	logic [mlfq_pkg::PID_W-1:0] run_pid;
	logic [mlfq_pkg::Q_W-1:0]   quantum;
	logic [mlfq_pkg::LVL_W-1:0] old_prio;
	logic                       deferred;
	logic                       status;

	modport source (
		output valid, switched, run_pid, quantum, old_prio, deferred, status,
		input  ready
	);
	modport sink (
		input  valid, switched, run_pid, quantum, old_prio, deferred, status,
		output ready
	);
endinterface

// ----- rtl/core/mlfq_levels.sv -----
module mlfq_levels #(
	parameter int NUM_PROCS = mlfq_pkg::DEFAULT_NUM_PROCS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mlfq_pkg::lvl_req_t lreq,
	output mlfq_pkg::lvl_rsp_t lrsp
);

	localparam int NUM_SLOTS = (NUM_PROCS < 2**mlfq_pkg::PID_W) ? NUM_PROCS
		: 2**mlfq_pkg::PID_W;
	localparam int SLOT_W = $clog2(NUM_SLOTS);

	logic [mlfq_pkg::NUM_LEVELS-1:0] nonempty_q;
	logic [mlfq_pkg::PID_W-1:0]      head_q [mlfq_pkg::NUM_LEVELS];
	logic [mlfq_pkg::PID_W-1:0]      tail_q [mlfq_pkg::NUM_LEVELS];
	logic [mlfq_pkg::PID_W-1:0]      link_q [NUM_SLOTS];

	logic [mlfq_pkg::NUM_LEVELS-1:0] push_sel;
	logic [mlfq_pkg::NUM_LEVELS-1:0] single;
	logic [mlfq_pkg::NUM_LEVELS-1:0] ne_post;
	logic [mlfq_pkg::NUM_LEVELS-1:0] ne_next;
	logic [mlfq_pkg::PID_W-1:0]      head_n [mlfq_pkg::NUM_LEVELS];
	logic [mlfq_pkg::PID_W-1:0]      tail_n [mlfq_pkg::NUM_LEVELS];
	logic [mlfq_pkg::PID_W-1:0]      push_tail;
	logic                            link_wr;
	logic [mlfq_pkg::PID_W-1:0]      pop_pid;
	logic                            pop_done;
	logic [mlfq_pkg::PID_W-1:0]      link_n;

	// Apply the pending push to every level's head and tail view
	always_comb begin
		for (int l = 0; l < mlfq_pkg::NUM_LEVELS; l++) begin
			push_sel[l] = lreq.push_en && (lreq.push_lvl == mlfq_pkg::LVL_W'(l));
			head_n[l] = (push_sel[l] && !nonempty_q[l]) ? lreq.push_pid : head_q[l];
			tail_n[l] = push_sel[l] ? lreq.push_pid : tail_q[l];
			single[l] = head_n[l] == tail_n[l];
		end
		ne_post = nonempty_q | push_sel;
	end

	// Pop the head of the chosen level, forwarding a link written by the push
	always_comb begin
		push_tail = tail_q[lreq.push_lvl];
		link_wr = lreq.push_en && nonempty_q[lreq.push_lvl];
		pop_pid = head_n[lreq.pop_lvl];
		pop_done = lreq.pop_en && ne_post[lreq.pop_lvl];
		link_n = (link_wr && push_tail == pop_pid) ? lreq.push_pid
			: link_q[pop_pid[SLOT_W-1:0]];
		ne_next = ne_post;
		if (pop_done && single[lreq.pop_lvl]) begin
			ne_next[lreq.pop_lvl] = 1'b0;
		end
	end

	assign lrsp.nonempty = nonempty_q;
	assign lrsp.pop_valid = pop_done;
	assign lrsp.pop_pid = pop_pid;

	// Track which levels hold a process
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonempty_q <= '0;
		end else if (lreq.commit) begin
			nonempty_q <= ne_next;
		end
	end

	// Update heads, tails and links; a pop after a push on one level wins on the head
	always_ff @(posedge clk) begin
		if (lreq.commit) begin
			if (lreq.push_en) begin
				if (!nonempty_q[lreq.push_lvl]) begin
					head_q[lreq.push_lvl] <= lreq.push_pid;
				end else begin
					link_q[push_tail[SLOT_W-1:0]] <= lreq.push_pid;
				end
				tail_q[lreq.push_lvl] <= lreq.push_pid;
			end
			if (pop_done && !single[lreq.pop_lvl]) begin
				head_q[lreq.pop_lvl] <= link_n;
			end
		end
	end

endmodule

// ----- rtl/core/multilevel_feedback_scheduler.sv -----
// A request beat goes through the input register, then the result register; one
// request can be taken every cycle unless rsp.ready stalls the result register.
// Throughput: 1 item per cycle when not stalled, set by the single decision path
// between the input and result registers. Reset (arst_n low) clears the running
// process to 0, all priorities and classes, the ready levels and the defer state.
module multilevel_feedback_scheduler #(
	parameter int NUM_PROCS = mlfq_pkg::DEFAULT_NUM_PROCS
) (
	input logic        clk,
	input logic        arst_n,
	mlfq_req_if.sink   req,
	mlfq_rsp_if.source rsp
);

	localparam int NUM_SLOTS = (NUM_PROCS < 2**mlfq_pkg::PID_W) ? NUM_PROCS
		: 2**mlfq_pkg::PID_W;
	localparam int SLOT_W = $clog2(NUM_SLOTS);

	// Input register
	logic                               v_s1;
	mlfq_pkg::func_t                    func_s1;
	logic [mlfq_pkg::PID_W-1:0]         target_pid_s1;
	logic [mlfq_pkg::LVL_W-1:0]         ready_prio_s1;
	logic [mlfq_pkg::STATE_W-1:0]       old_state_s1;
	logic                               old_yielded_s1;
	logic signed [mlfq_pkg::QL_W-1:0]   quantum_left_s1;

	// Result register
	logic                               v_s2;
	logic                               switched_s2;
	logic [mlfq_pkg::PID_W-1:0]         run_pid_s2;
	logic [mlfq_pkg::Q_W-1:0]           quantum_s2;
	logic [mlfq_pkg::LVL_W-1:0]         old_prio_s2;
	logic                               deferred_s2;
	logic                               status_s2;

	// Scheduler state
	logic [mlfq_pkg::PID_W-1:0]         cur_pid_q;
	logic [mlfq_pkg::LVL_W-1:0]         cur_prio_q;
	logic [mlfq_pkg::LVL_W-1:0]         prio_tbl_q [NUM_SLOTS];
	logic                               class_q [NUM_SLOTS];
	logic [mlfq_pkg::CNT_W-1:0]         defer_cnt_q;
	logic                               attempt_q;

	mlfq_pkg::lvl_req_t                 lreq;
	mlfq_pkg::lvl_rsp_t                 lrsp;

	logic                               adv;
	logic                               take;
	logic [SLOT_W-1:0]                  cur_slot;
	logic [SLOT_W-1:0]                  mr_slot;
	logic                               orig_cls;
	logic                               new_cls;
	logic                               qpos;
	logic [mlfq_pkg::LVL_W-1:0]         prio_new;
	logic [mlfq_pkg::LVL_W-1:0]         top_lvl;
	logic                               cnt_zero;
	logic                               do_resched;
	logic                               is_cur;
	logic                               keep;
	logic                               mr_ok;
	logic                               mr_bad;
	logic                               mr_is_cur;
	logic [mlfq_pkg::LVL_W-1:0]         mr_lvl;
	logic                               switch_now;
	logic [mlfq_pkg::LVL_W-1:0]         np;
	logic [mlfq_pkg::LVL_W-1:0]         res_old_prio;
	logic                               res_status;
	logic                               res_deferred;

	// Handshake: the result register frees the input register
	assign adv = v_s1 && (!v_s2 || rsp.ready);
	assign req.ready = !v_s1 || adv;
	assign take = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2 <= 1'b1;
			end else if (rsp.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// Capture the request beat
	always_ff @(posedge clk) begin
		if (take) begin
			func_s1 <= mlfq_pkg::func_t'(req.func);
			target_pid_s1 <= req.target_pid;
			ready_prio_s1 <= req.ready_prio;
			old_state_s1 <= req.old_state;
			old_yielded_s1 <= req.old_yielded;
			quantum_left_s1 <= req.quantum_left;
		end
	end

	// Reclassify the running process and adjust its priority
	always_comb begin
		cur_slot = cur_pid_q[SLOT_W-1:0];
		orig_cls = class_q[cur_slot];
		qpos = (quantum_left_s1 != '0) && !quantum_left_s1[mlfq_pkg::QL_W-1];
		is_cur = old_state_s1 == mlfq_pkg::ST_CURRENT;
		if (old_state_s1 == mlfq_pkg::ST_BLOCKED) begin
			new_cls = mlfq_pkg::CLS_IO;
		end else if (is_cur && old_yielded_s1) begin
			new_cls = mlfq_pkg::CLS_IO;
		end else if (is_cur && qpos) begin
			new_cls = mlfq_pkg::CLS_CPU;
		end else begin
			new_cls = orig_cls;
		end
		prio_new = mlfq_pkg::adjust_prio(cur_prio_q, orig_cls, new_cls);
	end

	// Find the highest non-empty level above zero, else zero
	always_comb begin
		top_lvl = '0;
		for (int i = 1; i < mlfq_pkg::NUM_LEVELS; i++) begin
			if (lrsp.nonempty[i]) begin
				top_lvl = mlfq_pkg::LVL_W'(i);
			end
		end
	end

	// Decide the action for the item in the input register
	always_comb begin
		cnt_zero = defer_cnt_q == '0;
		do_resched = v_s1 && ((func_s1 == mlfq_pkg::FUNC_RESCHED && cnt_zero)
			|| (func_s1 == mlfq_pkg::FUNC_DEFER_STOP && defer_cnt_q == 8'd1 && attempt_q));
		keep = do_resched && is_cur && (prio_new > top_lvl);
		mr_bad = {28'd0, target_pid_s1} >= 32'(NUM_PROCS);
		mr_ok = v_s1 && func_s1 == mlfq_pkg::FUNC_MAKE_READY && !mr_bad;
		mr_lvl = (ready_prio_s1 > mlfq_pkg::TOP_PRIO) ? mlfq_pkg::TOP_PRIO : ready_prio_s1;
		mr_slot = target_pid_s1[SLOT_W-1:0];
		mr_is_cur = target_pid_s1 == cur_pid_q;

		lreq.commit = adv;
		lreq.push_en = mr_ok || (do_resched && is_cur && !keep);
		lreq.push_lvl = mr_ok ? mr_lvl : prio_new;
		lreq.push_pid = mr_ok ? target_pid_s1 : cur_pid_q;
		lreq.pop_en = do_resched && !keep;
		lreq.pop_lvl = top_lvl;

		switch_now = lrsp.pop_valid;
		np = (lrsp.pop_pid == cur_pid_q) ? prio_new
			: prio_tbl_q[lrsp.pop_pid[SLOT_W-1:0]];

		if (do_resched) begin
			res_old_prio = prio_new;
		end else if (mr_ok && mr_is_cur) begin
			res_old_prio = mr_lvl;
		end else begin
			res_old_prio = cur_prio_q;
		end
		res_deferred = func_s1 == mlfq_pkg::FUNC_RESCHED && !cnt_zero;
		res_status = (func_s1 == mlfq_pkg::FUNC_DEFER_STOP && cnt_zero)
			|| (func_s1 == mlfq_pkg::FUNC_MAKE_READY && mr_bad)
			|| (do_resched && !keep && !switch_now);
	end

	mlfq_levels #(
		.NUM_PROCS(NUM_PROCS)
	) u_levels (
		.clk    (clk),
		.arst_n (arst_n),
		.lreq   (lreq),
		.lrsp   (lrsp)
	);

	// Commit scheduler state as the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_pid_q <= '0;
			cur_prio_q <= '0;
			defer_cnt_q <= '0;
			attempt_q <= 1'b0;
			for (int s = 0; s < NUM_SLOTS; s++) begin
				prio_tbl_q[s] <= '0;
				class_q[s] <= mlfq_pkg::CLS_CPU;
			end
		end else if (adv) begin
			if (do_resched) begin
				class_q[cur_slot] <= new_cls;
				prio_tbl_q[cur_slot] <= prio_new;
				cur_prio_q <= switch_now ? np : prio_new;
				if (switch_now) begin
					cur_pid_q <= lrsp.pop_pid;
				end
			end
			if (mr_ok) begin
				prio_tbl_q[mr_slot] <= mr_lvl;
				if (mr_is_cur) begin
					cur_prio_q <= mr_lvl;
				end
			end
			unique case (func_s1)
				mlfq_pkg::FUNC_RESCHED: begin
					if (!cnt_zero) begin
						attempt_q <= 1'b1;
					end
				end
				mlfq_pkg::FUNC_DEFER_START: begin
					if (cnt_zero) begin
						attempt_q <= 1'b0;
					end
					if (defer_cnt_q != mlfq_pkg::DEFER_MAX) begin
						defer_cnt_q <= defer_cnt_q + 8'd1;
					end
				end
				mlfq_pkg::FUNC_DEFER_STOP: begin
					if (!cnt_zero) begin
						defer_cnt_q <= defer_cnt_q - 8'd1;
					end
				end
				mlfq_pkg::FUNC_MAKE_READY: begin
					attempt_q <= attempt_q;
				end
				default: begin
					attempt_q <= attempt_q;
				end
			endcase
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (adv) begin
			switched_s2 <= switch_now;
			run_pid_s2 <= switch_now ? lrsp.pop_pid : cur_pid_q;
			quantum_s2 <= switch_now ? mlfq_pkg::quantum_of(np) : '0;
			old_prio_s2 <= res_old_prio;
			deferred_s2 <= res_deferred;
			status_s2 <= res_status;
		end
	end

	assign rsp.valid = v_s2;
	assign rsp.switched = switched_s2;
	assign rsp.run_pid = run_pid_s2;
	assign rsp.quantum = quantum_s2;
	assign rsp.old_prio = old_prio_s2;
	assign rsp.deferred = deferred_s2;
	assign rsp.status = status_s2;

endmodule

// ----- rtl/core/mlfq_checker.sv -----
`include "multilevel_feedback_scheduler_defines.svh"

module mlfq_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic                       rsp_switched,
	input logic [mlfq_pkg::PID_W-1:0] rsp_run_pid,
	input logic [mlfq_pkg::Q_W-1:0]   rsp_quantum,
	input logic                       rsp_deferred,
	input logic                       rsp_status
);

	// Hold a stalled result beat
	`MLFQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_run_pid) && $stable(rsp_quantum) && $stable(rsp_switched) && $stable(rsp_status), "result changed while stalled")

	// A quantum is handed out exactly on a dispatch
	`MLFQ_ASSERT_NOW(a_quantum_dispatch, clk, arst_n, rsp_valid, rsp_switched == (rsp_quantum != '0), "quantum does not match dispatch")

	// A deferred attempt neither dispatches nor fails
	`MLFQ_ASSERT_NOW(a_deferred_quiet, clk, arst_n, rsp_valid && rsp_deferred, !rsp_switched && !rsp_status, "deferred result dispatched or failed")

	// A dispatch never reports an error
	`MLFQ_ASSERT_NOW(a_switch_ok, clk, arst_n, rsp_valid && rsp_switched, !rsp_status, "dispatch reported an error")

endmodule

bind multilevel_feedback_scheduler mlfq_checker u_mlfq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_switched (rsp.switched),
	.rsp_run_pid  (rsp.run_pid),
	.rsp_quantum  (rsp.quantum),
	.rsp_deferred (rsp.deferred),
	.rsp_status   (rsp.status)
);
